// ===== rtl/core/sfcv_pkg.sv =====
// Package for the serial frame checksum validator.
// Holds the payload structs, the per-frame state struct and the framing constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sfcv_pkg;

    localparam int unsigned MAX_FRAME_DEFAULT = 1024;
    localparam int unsigned LEN_W             = 11;

    localparam logic [7:0] BYTE_AA = 8'hAA;
    localparam logic [7:0] BYTE_BB = 8'hBB;
    localparam logic [7:0] BYTE_CC = 8'hCC;
    localparam logic [7:0] BYTE_DD = 8'hDD;
    localparam logic [7:0] BYTE_EE = 8'hEE;
    localparam logic [7:0] BYTE_55 = 8'h55;
    localparam logic [7:0] BYTE_56 = 8'h56;

    localparam logic [1:0] RULE_NONE       = 2'd0;
    localparam logic [1:0] RULE_ACK_NAK    = 2'd1;
    localparam logic [1:0] RULE_TERMINATOR = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } sfcv_in_t;

    typedef struct packed {
        logic             frame_ok;
        logic [LEN_W-1:0] frame_length;
        logic [1:0]       matched_rule;
        logic             too_long;
    } sfcv_out_t;

    // Per-frame scan state; the width-dependent counters travel beside it.
    typedef struct packed {
        logic [7:0]      running_xor;
        logic [3:0][7:0] history;      // entry 0 is the newest byte
        logic            starts_ack_nak;
        logic            byte_four_special;
        logic            terminator_found;
    } sfcv_state_t;

endpackage : sfcv_pkg

`default_nettype wire

// ===== rtl/core/sfcv_eval.sv =====
// Per-byte evaluation logic of the serial frame checksum validator.
// Computes the next scan state and the frame verdict; depends on sfcv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfcv_eval import sfcv_pkg::*; #(
    parameter int unsigned MAX_FRAME = MAX_FRAME_DEFAULT,
    parameter int unsigned CNT_W     = $clog2(MAX_FRAME + 2)
) (
    input  wire sfcv_state_t      state_i,
    input  wire logic [CNT_W-1:0] count_i,
    input  wire logic [CNT_W-1:0] found_len_i,
    input  wire sfcv_in_t         in_i,
    output sfcv_state_t           state_o,
    output logic [CNT_W-1:0]      count_o,
    output logic [CNT_W-1:0]      found_len_o,
    output sfcv_out_t             result_o
);

    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_FRAME);

    always_comb begin
        logic [7:0]         b;
        logic               in_range;
        logic               sw_n;
        logic               b4_n;
        logic               plain;
        logic               hit;
        logic               found_n;
        logic [CNT_W-1:0]   flen_n;
        logic [CNT_W-1:0]   cnt_n;
        logic               short_len;
        logic [CNT_W+LEN_W-1:0] len_wide;
        logic [CNT_W+LEN_W-1:0] flen_wide;
        logic [CNT_W+LEN_W-1:0] max_wide;
        sfcv_state_t        upd;

        b        = in_i.data_byte;
        in_range = count_i <= MAX_C;

        sw_n = state_i.starts_ack_nak |
               (in_range && count_i == CNT_W'(1) && state_i.history[0] == BYTE_AA &&
                (b inside {BYTE_DD, BYTE_EE}));
        b4_n = state_i.byte_four_special |
               (in_range && count_i == CNT_W'(4) && (b inside {BYTE_55, BYTE_56}));

        plain = state_i.history[3] != BYTE_AA && state_i.history[2] != BYTE_BB;
        hit   = in_range && count_i >= CNT_W'(4) && count_i < MAX_C &&
                !state_i.terminator_found &&
                state_i.history[1] == BYTE_AA && state_i.history[0] == BYTE_CC &&
                (plain || b4_n) && b == state_i.running_xor;

        found_n = state_i.terminator_found | hit;
        flen_n  = hit ? count_i + CNT_W'(1) : found_len_i;
        cnt_n   = in_range ? count_i + CNT_W'(1) : count_i;

        upd.running_xor       = state_i.running_xor ^ b;
        upd.history           = {state_i.history[2:0], b};
        upd.starts_ack_nak    = sw_n;
        upd.byte_four_special = b4_n;
        upd.terminator_found  = found_n;

        // A verdict closes the frame, so the scan state starts afresh.
        if (in_i.last_byte) begin
            state_o     = '0;
            count_o     = '0;
            found_len_o = '0;
        end else begin
            state_o     = upd;
            count_o     = cnt_n;
            found_len_o = flen_n;
        end

        short_len = cnt_n == CNT_W'(5) || cnt_n == CNT_W'(6) ||
                    cnt_n == CNT_W'(8) || cnt_n == CNT_W'(9);
        len_wide  = {{LEN_W{1'b0}}, cnt_n};
        flen_wide = {{LEN_W{1'b0}}, flen_n};
        max_wide  = {{LEN_W{1'b0}}, MAX_C};

        result_o              = '0;
        result_o.matched_rule = RULE_NONE;
        result_o.frame_length = len_wide[LEN_W-1:0];
        if (cnt_n > MAX_C) begin
            // An over-long frame reports the maximum frame size as its length.
            result_o.too_long     = 1'b1;
            result_o.frame_length = max_wide[LEN_W-1:0];
        end else if (cnt_n > CNT_W'(4)) begin
            if (sw_n && short_len) begin
                if (b == state_i.running_xor) begin
                    result_o.frame_ok     = 1'b1;
                    result_o.matched_rule = RULE_ACK_NAK;
                end
            end else if (found_n) begin
                result_o.frame_ok     = 1'b1;
                result_o.matched_rule = RULE_TERMINATOR;
                result_o.frame_length = flen_wide[LEN_W-1:0];
            end
        end
    end

endmodule : sfcv_eval

`default_nettype wire

// ===== rtl/core/serial_frame_checksum_validator_top.sv =====
// Top level of the serial frame checksum validator.
// Holds the scan state and the result register; uses sfcv_pkg and sfcv_eval.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-----------------------------------------
//  s_      | in        | s_valid / s_ready  | sfcv_in_t: data_byte, last_byte
//  m_      | out       | m_valid / m_ready  | sfcv_out_t: frame_ok, frame_length,
//          |           |                    |   matched_rule, too_long
//
// The evaluation logic sits between the scan-state registers and the result
// register, and a byte is accepted in every cycle unless the input stalls.
// A verdict appears on m_ the cycle after the frame's last byte is accepted.
// Synchronous active-low reset clears the scan state and the result valid flag.
// The input stalls only while a verdict is held in the result register and the
// downstream side is not taking it.
`timescale 1ns / 1ps
`default_nettype none

module serial_frame_checksum_validator_top import sfcv_pkg::*; #(
    parameter int unsigned MAX_FRAME = MAX_FRAME_DEFAULT
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire sfcv_in_t  s_payload,
    output logic           m_valid,
    input  wire logic      m_ready,
    output sfcv_out_t      m_payload
);

    // The byte count saturates one past the maximum frame size, so that an
    // over-long frame is still recognised when its last byte arrives.
    localparam int unsigned CNT_W = $clog2(MAX_FRAME + 2);

    sfcv_state_t      state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] found_len_reg, found_len_next;
    sfcv_out_t        result;
    logic             m_valid_reg;
    sfcv_out_t        m_payload_reg;
    logic             s_accept;

    // The result register parts the two sides: a new byte is taken whenever the
    // register is empty or its verdict leaves in this same cycle.
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    sfcv_eval #(
        .MAX_FRAME (MAX_FRAME),
        .CNT_W     (CNT_W)
    ) u_eval (
        .state_i     (state_reg),
        .count_i     (count_reg),
        .found_len_i (found_len_reg),
        .in_i        (s_payload),
        .state_o     (state_next),
        .count_o     (count_next),
        .found_len_o (found_len_next),
        .result_o    (result)
    );

    // Scan state advances only on an accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            count_reg     <= '0;
            found_len_reg <= '0;
        end else if (s_accept) begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            found_len_reg <= found_len_next;
        end
    end

    // Result register: loaded by the last byte of a frame, emptied when taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept && s_payload.last_byte) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && s_payload.last_byte) begin
            m_payload_reg <= result;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule : serial_frame_checksum_validator_top

`default_nettype wire

// ===== rtl/core/sfcv_checker.sv =====
// Port-level checker for the serial frame checksum validator.
// Depends on sfcv_pkg; bound to serial_frame_checksum_validator_top below.
`timescale 1ns / 1ps
`default_nettype none

module sfcv_checker import sfcv_pkg::*; #(
    parameter int unsigned MAX_FRAME = MAX_FRAME_DEFAULT
) (
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire sfcv_in_t  s_payload,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire sfcv_out_t m_payload
);

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME);

    a_s_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_payload))
        else $error("input transaction changed while stalled");

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result transaction changed while stalled");

    a_ok_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload.frame_ok == (m_payload.matched_rule != RULE_NONE)))
        else $error("frame_ok disagrees with matched_rule");

    a_too_long: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.too_long |->
            !m_payload.frame_ok && m_payload.frame_length == MAX_LEN)
        else $error("over-long frame verdict malformed");

    a_ack_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.matched_rule == RULE_ACK_NAK |->
            m_payload.frame_length == LEN_W'(5) || m_payload.frame_length == LEN_W'(6) ||
            m_payload.frame_length == LEN_W'(8) || m_payload.frame_length == LEN_W'(9))
        else $error("short ACK/NAK verdict with an invalid length");

endmodule : sfcv_checker

bind serial_frame_checksum_validator_top sfcv_checker #(
    .MAX_FRAME (MAX_FRAME)
) u_sfcv_checker (.*);

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for serial_frame_checksum_validator_top.
// Drives byte transactions, predicts one verdict per frame and checks every result.
// Depends on sfcv_pkg and the validator top level only.
`timescale 1ns / 1ps

module tb;
    import sfcv_pkg::*;

    localparam int unsigned MAX_LEN      = MAX_FRAME_DEFAULT;
    localparam int unsigned RANDOM_BYTES = 600;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    sfcv_in_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    sfcv_out_t m_payload;

    serial_frame_checksum_validator_top #(
        .MAX_FRAME (MAX_LEN)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #5 aclk = ~aclk;

    // Scan state of the predictor; it mirrors what the block must hold for the frame
    // currently arriving and is cleared once the frame's verdict has been worked out.
    logic [7:0]  acc_xor;
    logic [7:0]  recent [0:3];    // recent[0] is the newest byte
    int unsigned seen_count;
    logic        ack_nak_head;
    logic        fifth_special;
    logic        cut_found;
    int unsigned cut_len;

    sfcv_out_t   verdicts_due [$];   // verdicts predicted but not yet delivered
    logic [7:0]  pending_frame [$];  // frame being assembled by a test
    sfcv_out_t   want_verdict;
    int unsigned fail_count   = 0;
    int unsigned rx_hold_left = 0;
    bit          steady       = 1'b0;  // when set, neither side inserts idle cycles

    task automatic clear_scan();
        acc_xor       = '0;
        recent        = '{default: '0};
        seen_count    = 0;
        ack_nak_head  = 1'b0;
        fifth_special = 1'b0;
        cut_found     = 1'b0;
        cut_len       = 0;
    endtask

    // Advances the predicted scan state by one accepted byte. On the frame's last
    // byte the verdict is computed and queued, and the scan state is cleared.
    task automatic predict_verdict(input logic [7:0] b, input logic last);
        int unsigned pos;
        logic [7:0]  prior;
        int unsigned len;
        sfcv_out_t   v;
        pos   = seen_count;
        prior = acc_xor;
        if (pos <= MAX_LEN) begin
            if (pos == 1 && recent[0] == BYTE_AA && (b == BYTE_DD || b == BYTE_EE)) begin
                ack_nak_head = 1'b1;
            end
            if (pos == 4 && (b == BYTE_55 || b == BYTE_56)) begin
                fifth_special = 1'b1;
            end
            // A terminator needs AA CC just before it; of the two bytes ahead of those,
            // the first must not be AA and the second not BB, unless byte four was special.
            if (pos >= 4 && pos < MAX_LEN && !cut_found &&
                recent[1] == BYTE_AA && recent[0] == BYTE_CC &&
                ((recent[3] != BYTE_AA && recent[2] != BYTE_BB) || fifth_special) &&
                b == prior) begin
                cut_found = 1'b1;
                cut_len   = pos + 1;
            end
            seen_count = pos + 1;
        end
        acc_xor   = prior ^ b;
        recent[3] = recent[2];
        recent[2] = recent[1];
        recent[1] = recent[0];
        recent[0] = b;
        if (!last) begin
            return;
        end
        len            = seen_count;
        v              = '0;
        v.matched_rule = RULE_NONE;
        if (len > MAX_LEN) begin
            v.too_long     = 1'b1;
            v.frame_length = LEN_W'(MAX_LEN);
        end else begin
            v.frame_length = LEN_W'(len);
            if (len > 4) begin
                if (ack_nak_head && (len == 5 || len == 6 || len == 8 || len == 9)) begin
                    // The short rule excludes the terminator rule entirely.
                    if (b == prior) begin
                        v.frame_ok     = 1'b1;
                        v.matched_rule = RULE_ACK_NAK;
                    end
                end else if (cut_found) begin
                    v.frame_ok     = 1'b1;
                    v.matched_rule = RULE_TERMINATOR;
                    v.frame_length = LEN_W'(cut_len);
                end
            end
        end
        verdicts_due.push_back(v);
        clear_scan();
    endtask

    // Offers one byte transaction. It is entered just after a falling edge and
    // returns just after the falling edge that follows acceptance.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 22) begin
            gap = $urandom_range(1, 3);
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= {b, last};
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predict_verdict(b, last);
        @(negedge aclk);
    endtask

    task automatic send_frame();
        foreach (pending_frame[i]) begin
            send_byte(pending_frame[i], i == pending_frame.size() - 1);
        end
        pending_frame.delete();
    endtask

    // The sender stops offering and waits until every predicted verdict has arrived.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (verdicts_due.size() != 0) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    function automatic logic [7:0] pending_xor();
        logic [7:0] x;
        x = '0;
        foreach (pending_frame[i]) begin
            x ^= pending_frame[i];
        end
        return x;
    endfunction

    // Byte values weighted towards the framing markers so that rules get exercised.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 11))
            0:       return BYTE_AA;
            1:       return BYTE_BB;
            2:       return BYTE_CC;
            3:       return BYTE_DD;
            4:       return BYTE_EE;
            5:       return BYTE_55;
            6:       return BYTE_56;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic test_short_frames();
        pending_frame = '{8'hFF};
        send_frame();
        pending_frame = '{BYTE_AA, BYTE_DD};
        send_frame();
        pending_frame = '{8'h00, 8'hFF, 8'h00};
        send_frame();
        // Four bytes with a correct checksum are still too short to pass.
        pending_frame = '{BYTE_AA, BYTE_EE, 8'h44};
        pending_frame.push_back(pending_xor());
        send_frame();
    endtask

    task automatic test_ack_nak();
        pending_frame = '{BYTE_AA, BYTE_DD, 8'h00, 8'hFF};
        pending_frame.push_back(pending_xor());
        send_frame();
        pending_frame = '{BYTE_AA, BYTE_EE, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h10, 8'h20};
        pending_frame.push_back(pending_xor());
        send_frame();
        // Wrong checksum on a six-byte frame.
        pending_frame = '{BYTE_AA, BYTE_DD, 8'h12, 8'h34, 8'h56};
        pending_frame.push_back(pending_xor() ^ 8'h01);
        send_frame();
        // Seven bytes falls outside the short lengths, so the terminator rule applies.
        pending_frame = '{BYTE_AA, BYTE_EE, 8'h03, BYTE_AA, BYTE_CC, 8'h00};
        pending_frame.push_back(pending_xor());
        send_frame();
    endtask

    task automatic test_terminator();
        logic [7:0] x;
        // Plain terminator followed by a tail that the cut drops.
        pending_frame = '{8'h01, 8'h02, BYTE_AA, BYTE_CC};
        pending_frame.push_back(pending_xor());
        pending_frame.push_back(8'hFF);
        pending_frame.push_back(8'h00);
        send_frame();
        // AA BB ahead of AA CC blocks the position when byte four is ordinary.
        pending_frame = '{8'h00, BYTE_AA, BYTE_BB, BYTE_AA, BYTE_CC};
        pending_frame.push_back(pending_xor());
        send_frame();
        // The same pattern is accepted when byte four is 55.
        pending_frame = '{8'h00, 8'h01, 8'h02, 8'h03, BYTE_55, BYTE_AA, BYTE_BB, BYTE_AA,
                          BYTE_CC};
        pending_frame.push_back(pending_xor());
        send_frame();
        // The first candidate has a bad checksum; the second one is taken.
        pending_frame = '{8'h01, 8'h02, BYTE_AA, BYTE_CC};
        x = pending_xor() ^ 8'h01;
        pending_frame.push_back(x);
        pending_frame.push_back(8'h07);
        pending_frame.push_back(BYTE_AA);
        pending_frame.push_back(BYTE_CC);
        pending_frame.push_back(pending_xor());
        pending_frame.push_back(8'h09);
        send_frame();
    endtask

    task automatic test_frame_limit();
        // Exactly the maximum length, with a terminator on the very last byte.
        repeat (MAX_LEN - 3) pending_frame.push_back(8'($urandom_range(0, 8'h7F)));
        pending_frame.push_back(BYTE_AA);
        pending_frame.push_back(BYTE_CC);
        pending_frame.push_back(pending_xor());
        send_frame();
        // One byte over the maximum: the late terminator is ignored and the frame rejected.
        repeat (MAX_LEN - 2) pending_frame.push_back(8'($urandom_range(0, 8'h7F)));
        pending_frame.push_back(BYTE_AA);
        pending_frame.push_back(BYTE_CC);
        pending_frame.push_back(pending_xor());
        send_frame();
        wait_drained();
    endtask

    // The receiver holds off for a long stretch while single-byte frames keep
    // arriving, so the result register fills and the input has to stall.
    task automatic test_backpressure();
        rx_hold_left = 80;
        repeat (20) begin
            pending_frame.push_back(pick_byte());
            send_frame();
        end
        repeat (3) begin
            pending_frame = '{BYTE_AA, BYTE_DD, 8'($urandom), 8'($urandom)};
            pending_frame.push_back(pending_xor());
            send_frame();
        end
        wait_drained();
    endtask

    task automatic test_random();
        int unsigned sent;
        int unsigned n;
        int unsigned len;
        logic [7:0]  x;
        bit          paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_BYTES) begin
            steady = (sent >= 150 && sent < 300);
            if (!paused && sent >= 350) begin
                paused = 1'b1;
                wait_drained();
            end
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    // Short ACK/NAK frame, mostly with a good checksum.
                    pending_frame.push_back(BYTE_AA);
                    pending_frame.push_back($urandom_range(0, 1) ? BYTE_DD : BYTE_EE);
                    case ($urandom_range(0, 9))
                        0:       len = 7;
                        1:       len = 10;
                        2:       len = 4;
                        default: len = ($urandom_range(0, 1) ? 5 : 8) + $urandom_range(0, 1);
                    endcase
                    while (pending_frame.size() < len - 1) begin
                        pending_frame.push_back(pick_byte());
                    end
                    x = pending_xor();
                    if ($urandom_range(0, 99) >= 85) begin
                        x ^= 8'($urandom_range(1, 255));
                    end
                    pending_frame.push_back(x);
                end
                3, 4, 5, 6: begin
                    // Terminator frame: prefix, AA CC, checksum and a tail.
                    n = $urandom_range(2, 10);
                    repeat (n) pending_frame.push_back(pick_byte());
                    if ($urandom_range(0, 3) == 0) begin
                        pending_frame[n - 2] = BYTE_AA;
                        pending_frame[n - 1] = BYTE_BB;
                    end
                    if (n >= 5 && $urandom_range(0, 2) == 0) begin
                        pending_frame[4] = $urandom_range(0, 1) ? BYTE_55 : BYTE_56;
                    end
                    pending_frame.push_back(BYTE_AA);
                    pending_frame.push_back(BYTE_CC);
                    x = pending_xor();
                    if ($urandom_range(0, 99) >= 85) begin
                        x ^= 8'($urandom_range(1, 255));
                    end
                    pending_frame.push_back(x);
                    repeat ($urandom_range(0, 4)) pending_frame.push_back(pick_byte());
                end
                7, 8: begin
                    repeat ($urandom_range(1, 16)) pending_frame.push_back(pick_byte());
                end
                default: begin
                    n = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 4);
                    repeat (n) pending_frame.push_back(pick_byte());
                end
            endcase
            sent += pending_frame.size();
            send_frame();
        end
        steady = 1'b0;
    endtask

    // Receiver: a long hold-off when requested, else always ready while steady, else random.
    always @(negedge aclk) begin
        if (rx_hold_left > 0) begin
            m_ready      <= 1'b0;
            rx_hold_left = rx_hold_left - 1;
        end else begin
            m_ready <= steady || ($urandom_range(0, 99) >= 22);
        end
    end

    // Every result transaction is matched against the oldest predicted verdict.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (verdicts_due.size() == 0) begin
                $error("verdict with none expected: ok %0d length %0d rule %0d too_long %0d",
                       m_payload.frame_ok, m_payload.frame_length,
                       m_payload.matched_rule, m_payload.too_long);
                fail_count++;
            end else begin
                want_verdict = verdicts_due.pop_front();
                if (m_payload.frame_ok !== want_verdict.frame_ok) begin
                    $error("frame_ok: expected %0d, got %0d",
                           want_verdict.frame_ok, m_payload.frame_ok);
                    fail_count++;
                end
                if (m_payload.frame_length !== want_verdict.frame_length) begin
                    $error("frame_length: expected %0d, got %0d",
                           want_verdict.frame_length, m_payload.frame_length);
                    fail_count++;
                end
                if (m_payload.matched_rule !== want_verdict.matched_rule) begin
                    $error("matched_rule: expected %0d, got %0d",
                           want_verdict.matched_rule, m_payload.matched_rule);
                    fail_count++;
                end
                if (m_payload.too_long !== want_verdict.too_long) begin
                    $error("too_long: expected %0d, got %0d",
                           want_verdict.too_long, m_payload.too_long);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        clear_scan();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_short_frames();
        test_ack_nak();
        test_terminator();
        test_frame_limit();
        test_backpressure();
        test_random();
        wait_drained();
        repeat (4) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legitimate run.
    initial begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
